// ----- hw/rtl/lc_pkg.sv -----
// Shared types and register codes for the 2D line clipper.
// No dependencies; used by lc_div.sv, line_clipper_2d.sv and line_clipper_2d_tb.sv.
package lc_pkg;

    // Window register indexes on the configuration port.
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    localparam int NUM_EDGES = 4;

    // Per-edge status that travels alongside the divider pipeline.
    typedef struct packed {
        logic pzero;    // edge direction p is zero (segment parallel to edge)
        logic pneg;     // p is negative, so t is an entering bound
        logic qneg;     // q is negative, so a parallel segment lies outside
    } lc_edge_t;

endpackage

// ----- hw/rtl/lc_div.sv -----
// Pipelined fixed-point divider for one clip edge: t = round(q / p), saturated.
// Restoring division, one quotient bit per stage. Depends on lc_pkg.
module lc_div #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [COORD_BITS:0]      p_in,
    input  logic signed [COORD_BITS:0]      q_in,
    output logic signed [FRAC_BITS+2:0]     t_out,
    output lc_pkg::lc_edge_t                flags_out
);
    import lc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int STEPS = F + 1;

    logic [C:0]   up_s  [0:STEPS];
    logic [C:0]   r_s   [0:STEPS];
    logic [F:0]   acc_s [0:STEPS];
    logic         ip_s  [0:STEPS];
    logic         sat_s [0:STEPS];
    logic         neg_s [0:STEPS];
    lc_edge_t     fl_s  [0:STEPS];

    logic [C:0]   uq;
    logic [C:0]   up;
    logic         ip0;
    logic         sat0;

    always_comb
    begin
        uq   = q_in[C] ? (C+1)'(0) - q_in : q_in;
        up   = p_in[C] ? (C+1)'(0) - p_in : p_in;
        sat0 = {1'b0, uq} >= {up, 1'b0};
        ip0  = uq >= up;
    end

    // Magnitudes, integer part and saturation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up_s[0]        <= up;
            r_s[0]         <= ip0 ? uq - up : uq;
            acc_s[0]       <= '0;
            ip_s[0]        <= ip0;
            sat_s[0]       <= sat0;
            neg_s[0]       <= q_in[C] ^ p_in[C];
            fl_s[0].pzero  <= (p_in == '0);
            fl_s[0].pneg   <= p_in[C];
            fl_s[0].qneg   <= q_in[C];
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [C+1:0] r2;
        logic         ge;
        logic [C+1:0] rdiff;

        always_comb
        begin
            r2    = {r_s[k-1], 1'b0};
            ge    = r2 >= {1'b0, up_s[k-1]};
            rdiff = r2 - {1'b0, up_s[k-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                up_s[k]  <= up_s[k-1];
                r_s[k]   <= ge ? rdiff[C:0] : r2[C:0];
                acc_s[k] <= {acc_s[k-1][F-1:0], ge};
                ip_s[k]  <= ip_s[k-1];
                sat_s[k] <= sat_s[k-1];
                neg_s[k] <= neg_s[k-1];
                fl_s[k]  <= fl_s[k-1];
            end
        end
    end

    // The quotient carries one extra fraction bit that rounds half away from zero.
    logic [F+2:0] mag_full;
    logic [F+1:0] mag;
    logic [F+2:0] mag_ext;

    always_comb
    begin
        mag_full = {1'b0, ip_s[STEPS], acc_s[STEPS]} + (F+3)'(1);
        mag      = sat_s[STEPS] ? (F+2)'(2) << F : mag_full[F+2:1];
        mag_ext  = {1'b0, mag};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_out     <= neg_s[STEPS] ? (F+3)'(0) - mag_ext : mag_ext;
            flags_out <= fl_s[STEPS];
        end
    end

endmodule

// ----- hw/rtl/line_clipper_2d.sv -----
// Top level of the Liang-Barsky 2D line clipper: window registers and pipeline.
// Depends on lc_pkg and lc_div (four instances, one per window edge).
//
//  channel  signals                                    direction
//  in       in_valid, in_stall, start_x..end_y          segment in
//  out      out_valid, out_stall, visible, clip_*       clipped segment out
//  cfg      cfg_we, cfg_index, cfg_data                 window register write
//
// One segment per cycle unless a held result stalls the output; the restoring
// dividers produce one quotient bit per stage, so their depth follows FRAC_BITS.
// Reset clears the valid bits and loads the default window.
// A stalled output freezes the whole pipeline; in_stall follows it directly.
module line_clipper_2d #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          visible,
    output logic signed [COORD_BITS-1:0]  clip_x0,
    output logic signed [COORD_BITS-1:0]  clip_y0,
    output logic signed [COORD_BITS-1:0]  clip_x1,
    output logic signed [COORD_BITS-1:0]  clip_y1,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data
);
    import lc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int TW  = F + 3;
    localparam int LAT = F + 3;
    localparam int PW  = C + 1 + F;
    localparam logic signed [TW-1:0] T_ONE = {2'b00, 1'b1, {F{1'b0}}};

    logic signed [C-1:0] win_left_reg, win_right_reg, win_bottom_reg, win_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_right_reg  <= C'(639);
            win_bottom_reg <= '0;
            win_top_reg    <= C'(479);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT:   win_left_reg   <= cfg_data;
                REG_RIGHT:  win_right_reg  <= cfg_data;
                REG_BOTTOM: win_bottom_reg <= cfg_data;
                REG_TOP:    win_top_reg    <= cfg_data;
                default:    win_left_reg   <= win_left_reg;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage A: edge terms.
    logic signed [C:0] dx, dy, sx, sy;
    logic signed [C:0] p_next [0:NUM_EDGES-1];
    logic signed [C:0] q_next [0:NUM_EDGES-1];

    always_comb
    begin
        sx = {start_x[C-1], start_x};
        sy = {start_y[C-1], start_y};
        dx = {end_x[C-1], end_x} - sx;
        dy = {end_y[C-1], end_y} - sy;
        p_next[0] = -dx;
        q_next[0] = sx - {win_left_reg[C-1], win_left_reg};
        p_next[1] = dx;
        q_next[1] = {win_right_reg[C-1], win_right_reg} - sx;
        p_next[2] = -dy;
        q_next[2] = sy - {win_bottom_reg[C-1], win_bottom_reg};
        p_next[3] = dy;
        q_next[3] = {win_top_reg[C-1], win_top_reg} - sy;
    end

    logic signed [C:0]   p_reg [0:NUM_EDGES-1];
    logic signed [C:0]   q_reg [0:NUM_EDGES-1];
    logic signed [C-1:0] x_dl  [0:LAT];
    logic signed [C-1:0] y_dl  [0:LAT];
    logic signed [C:0]   dx_dl [0:LAT];
    logic signed [C:0]   dy_dl [0:LAT];
    logic                v_dl  [0:LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_EDGES; i++)
            begin
                p_reg[i] <= p_next[i];
                q_reg[i] <= q_next[i];
            end
            x_dl[0]  <= start_x;
            y_dl[0]  <= start_y;
            dx_dl[0] <= dx;
            dy_dl[0] <= dy;
            for (int k = 1; k <= LAT; k++)
            begin
                x_dl[k]  <= x_dl[k-1];
                y_dl[k]  <= y_dl[k-1];
                dx_dl[k] <= dx_dl[k-1];
                dy_dl[k] <= dy_dl[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAT; k++)
            begin
                v_dl[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_dl[0] <= in_valid;
            for (int k = 1; k <= LAT; k++)
            begin
                v_dl[k] <= v_dl[k-1];
            end
        end
    end

    logic signed [TW-1:0] t_edge  [0:NUM_EDGES-1];
    lc_edge_t             fl_edge [0:NUM_EDGES-1];

    for (genvar e = 0; e < NUM_EDGES; e++)
    begin : g_edge
        lc_div #(
            .COORD_BITS (C),
            .FRAC_BITS  (F)
        ) u_div (
            .clk       (clk),
            .en        (adv),
            .p_in      (p_reg[e]),
            .q_in      (q_reg[e]),
            .t_out     (t_edge[e]),
            .flags_out (fl_edge[e])
        );
    end

    // Stage D: narrow the parameter interval.
    logic signed [TW-1:0] tl, tu;
    logic                 reject;

    always_comb
    begin
        tl     = '0;
        tu     = T_ONE;
        reject = 1'b0;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            if (fl_edge[i].pzero)
            begin
                reject = reject | fl_edge[i].qneg;
            end
            else if (fl_edge[i].pneg)
            begin
                if (t_edge[i] > tl)
                    tl = t_edge[i];
            end
            else
            begin
                if (t_edge[i] < tu)
                    tu = t_edge[i];
            end
        end
    end

    logic signed [TW-1:0] tl_reg, tu_reg;
    logic                 ok_reg;
    logic signed [C-1:0]  x_d_reg, y_d_reg;
    logic signed [C:0]    dx_d_reg, dy_d_reg;
    logic                 v_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tl_reg   <= tl;
            tu_reg   <= tu;
            ok_reg   <= !reject && (tl <= tu);
            x_d_reg  <= x_dl[LAT];
            y_d_reg  <= y_dl[LAT];
            dx_d_reg <= dx_dl[LAT];
            dy_d_reg <= dy_dl[LAT];
        end
    end

    // Stage M: scale the deltas by the bounds. Lanes: x0, y0, x1, y1.
    logic [PW-1:0]       prod_reg  [0:NUM_EDGES-1];
    logic                dneg_reg  [0:NUM_EDGES-1];
    logic                full_reg  [0:NUM_EDGES-1];
    logic                zero_reg  [0:NUM_EDGES-1];
    logic signed [C-1:0] start_reg [0:NUM_EDGES-1];
    logic signed [C:0]   delta_reg [0:NUM_EDGES-1];
    logic                ok_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < NUM_EDGES; l++)
            begin
                logic signed [TW-1:0] t;
                logic signed [C:0]    d;
                logic [C:0]           dmag;
                t    = (l < 2) ? tl_reg : tu_reg;
                d    = (l % 2 == 0) ? dx_d_reg : dy_d_reg;
                dmag = d[C] ? (C+1)'(0) - d : d;
                prod_reg[l]  <= PW'(dmag) * PW'(t[F-1:0]);
                dneg_reg[l]  <= d[C];
                full_reg[l]  <= t >= T_ONE;
                zero_reg[l]  <= t <= '0;
                start_reg[l] <= (l % 2 == 0) ? x_d_reg : y_d_reg;
                delta_reg[l] <= d;
            end
            ok_m_reg <= ok_reg;
        end
    end

    // Stage O: round and place the endpoints.
    logic signed [C-1:0] pt [0:NUM_EDGES-1];

    always_comb
    begin
        for (int l = 0; l < NUM_EDGES; l++)
        begin
            logic [PW-1:0]       rsum;
            logic signed [C+1:0] r;
            logic signed [C+1:0] s;
            logic signed [C+1:0] sum;
            rsum = prod_reg[l] + (PW'(1) << (F - 1));
            r    = (C+2)'(rsum >> F);
            s    = {{2{start_reg[l][C-1]}}, start_reg[l]};
            if (full_reg[l])
                sum = s + {delta_reg[l][C], delta_reg[l]};
            else if (zero_reg[l])
                sum = s;
            else if (dneg_reg[l])
                sum = s - r;
            else
                sum = s + r;
            pt[l] = ok_m_reg ? sum[C-1:0] : '0;
        end
    end

    logic v_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg       <= 1'b0;
            v_m_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_d_reg       <= v_dl[LAT];
            v_m_reg       <= v_d_reg;
            out_valid_reg <= v_m_reg;
        end
    end

    logic                visible_reg;
    logic signed [C-1:0] clip_x0_reg, clip_y0_reg, clip_x1_reg, clip_y1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visible_reg <= ok_m_reg;
            clip_x0_reg <= pt[0];
            clip_y0_reg <= pt[1];
            clip_x1_reg <= pt[2];
            clip_y1_reg <= pt[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign clip_x0   = clip_x0_reg;
    assign clip_y0   = clip_y0_reg;
    assign clip_x1   = clip_x1_reg;
    assign clip_y1   = clip_y1_reg;

    // A rejected segment carries zero endpoints.
    a_zero_when_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> clip_x0 == '0 && clip_y0 == '0
                                  && clip_x1 == '0 && clip_y1 == '0)
        else $error("hidden segment with nonzero endpoints");

    // The input side stalls exactly when a finished result is held.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output backpressure");

    // A held result keeps its visibility until the transfer.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(visible))
        else $error("held result changed");

endmodule

// ----- sim/line_clipper_2d_tb.sv -----
// Self-checking testbench for line_clipper_2d: clips segments against several windows
// and compares every output transfer with a built-in Liang-Barsky predictor.
// Depends on lc_pkg and the line_clipper_2d RTL.
module line_clipper_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lc_pkg::*;

    localparam int CW = 16;
    localparam int FB = 16;
    localparam longint T_ONE = 64'sd1 <<< FB;
    localparam int LATENCY = FB + 7;

    typedef struct packed {
        logic          vis;
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } clip_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] start_x, start_y, end_x, end_y;
    logic out_valid;
    logic out_stall;
    logic visible;
    logic signed [CW-1:0] clip_x0, clip_y0, clip_x1, clip_y1;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    longint win_l, win_r, win_b, win_t;
    clip_result_t expected_clips[$];
    int errors;
    int hold_off_cycles;

    line_clipper_2d #(.COORD_BITS(CW), .FRAC_BITS(FB)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("line_clipper_2d_tb failed");
        $finish;
    end

    // Rounded q/p with FB fraction bits, halves away from zero, saturated at 2.0.
    function automatic longint edge_t(longint q, longint p);
        logic neg;
        longint uq, up, mag, ip, r, acc;
        neg = (q < 0) != (p < 0);
        uq = (q < 0) ? -q : q;
        up = (p < 0) ? -p : p;
        if (uq >= 2 * up)
            mag = 2 * T_ONE;
        else
        begin
            ip = (uq >= up) ? 1 : 0;
            r = uq - ip * up;
            acc = 0;
            for (int i = 0; i < FB + 1; i++)
            begin
                r = r <<< 1;
                acc = acc <<< 1;
                if (r >= up)
                begin
                    r -= up;
                    acc |= 1;
                end
            end
            mag = ((ip <<< (FB + 1)) | acc);
            mag = (mag + 1) >>> 1;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic longint point_at(longint s, longint d, longint t);
        longint mag, r;
        if (t >= T_ONE)
            return s + d;
        if (t <= 0)
            return s;
        mag = (d < 0) ? -d : d;
        r = (mag * t + (64'sd1 <<< (FB - 1))) >>> FB;
        return (d < 0) ? s - r : s + r;
    endfunction

    function automatic clip_result_t clip_segment(longint x1, longint y1,
                                                  longint x2, longint y2);
        longint dx, dy, tl, tu, t;
        longint p[4], q[4];
        logic ok;
        clip_result_t res;
        dx = x2 - x1;
        dy = y2 - y1;
        tl = 0;
        tu = T_ONE;
        ok = 1'b1;
        p[0] = -dx; q[0] = x1 - win_l;
        p[1] = dx;  q[1] = win_r - x1;
        p[2] = -dy; q[2] = y1 - win_b;
        p[3] = dy;  q[3] = win_t - y1;
        for (int i = 0; i < NUM_EDGES; i++)
        begin
            if (p[i] == 0)
            begin
                if (q[i] < 0)
                    ok = 1'b0;
            end
            else
            begin
                t = edge_t(q[i], p[i]);
                if (p[i] < 0)
                begin
                    if (t > tu) ok = 1'b0;
                    else if (t > tl) tl = t;
                end
                else
                begin
                    if (t < tl) ok = 1'b0;
                    else if (t < tu) tu = t;
                end
            end
        end
        res = '0;
        if (ok)
        begin
            res.vis = 1'b1;
            res.x0 = CW'(point_at(x1, dx, tl));
            res.y0 = CW'(point_at(y1, dy, tl));
            res.x1 = CW'(point_at(x1, dx, tu));
            res.y1 = CW'(point_at(y1, dy, tu));
        end
        return res;
    endfunction

    // Result checker and receiver-side stalls.
    initial
    begin
        int gap;
        clip_result_t exp_r;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
            if (hold_off_cycles > 0)
            begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            out_stall <= (gap != 0);
            repeat (gap) @(posedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (expected_clips.size() == 0)
            begin
                $error("output transfer with no segment outstanding");
                errors++;
            end
            else
            begin
                exp_r = expected_clips.pop_front();
                if (visible !== exp_r.vis)
                begin
                    $error("visible: expected %0d actual %0d", exp_r.vis, visible);
                    errors++;
                end
                if (clip_x0 !== exp_r.x0)
                begin
                    $error("clip_x0: expected %0d actual %0d",
                           $signed(exp_r.x0), clip_x0);
                    errors++;
                end
                if (clip_y0 !== exp_r.y0)
                begin
                    $error("clip_y0: expected %0d actual %0d",
                           $signed(exp_r.y0), clip_y0);
                    errors++;
                end
                if (clip_x1 !== exp_r.x1)
                begin
                    $error("clip_x1: expected %0d actual %0d",
                           $signed(exp_r.x1), clip_x1);
                    errors++;
                end
                if (clip_y1 !== exp_r.y1)
                begin
                    $error("clip_y1: expected %0d actual %0d",
                           $signed(exp_r.y1), clip_y1);
                    errors++;
                end
            end
        end
    end

    // Offers one segment, waits for the transfer, then records the prediction.
    task automatic send_segment(int sx, int sy, int ex, int ey);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= CW'(sx);
        start_y <= CW'(sy);
        end_x <= CW'(ex);
        end_y <= CW'(ey);
        do @(posedge clk); while (in_stall);
        expected_clips.push_back(clip_segment(sx, sy, ex, ey));
    endtask

    task automatic drain_pipeline();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (expected_clips.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_window(int l, int r, int b, int t);
        logic [1:0] idx[4];
        int vals[4];
        idx = '{REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP};
        vals = '{l, r, b, t};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= CW'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        win_l = l;
        win_r = r;
        win_b = b;
        win_t = t;
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1, 2: return $signed(16'($urandom()));
            default: return $urandom_range(0, 1400) - 700;
        endcase
    endfunction

    task automatic test_reset_window_directed();
        send_segment(-100, 240, 800, 240);       // crosses left and right
        send_segment(320, -50, 320, 600);        // crosses bottom and top
        send_segment(0, 0, 0, 479);              // lies on the left edge
        send_segment(-5, 0, 700, 0);             // lies on the bottom edge
        send_segment(-1, -1, -1, 300);           // parallel, just outside
        send_segment(100, 100, 100, 100);        // point inside
        send_segment(639, 479, 639, 479);        // point on the corner
        send_segment(640, 10, 640, 10);          // point outside
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 32767, -32768, 32767);
        send_segment(-10, 489, 10, 469);         // touches a corner region
        send_segment(-20, 500, 700, -30);
        send_segment(639, 479, 700, 600);        // starts on the corner
        send_segment(50, 50, 600, 400);          // wholly inside
        drain_pipeline();
    endtask

    task automatic test_window_extremes();
        write_window(-32768, 32767, -32768, 32767);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, 32767, -32768, 0);
        send_segment(1, 2, 1, 2);
        drain_pipeline();
        write_window(5, 5, -7, -7);              // window of one point
        send_segment(0, -12, 10, -2);
        send_segment(5, -7, 5, -7);
        send_segment(0, 0, 10, 0);
        drain_pipeline();
        write_window(100, 50, 0, 479);           // inverted window
        send_segment(0, 10, 200, 10);
        send_segment(75, 10, 75, 10);
        drain_pipeline();
    endtask

    task automatic test_random_windows(int n_items);
        int a, b, c, d;
        for (int w = 0; w < 6; w++)
        begin
            a = rand_coord();
            b = rand_coord();
            c = rand_coord();
            d = rand_coord();
            // Mostly ordered windows so that many segments end up visible.
            if (w != 5)
                write_window(a < b ? a : b, a < b ? b : a,
                             c < d ? c : d, c < d ? d : c);
            else
                write_window(a, b, c, d);
            for (int i = 0; i < n_items / 6; i++)
                send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            drain_pipeline();
        end
    endtask

    // Receiver holds off long enough for the pipeline to fill and back-pressure.
    task automatic test_output_backpressure();
        write_window(-300, 300, -200, 200);
        hold_off_cycles = 3 * LATENCY + 20;
        for (int i = 0; i < 80; i++)
            send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        drain_pipeline();
    endtask

    initial
    begin
        errors = 0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LEFT;
        cfg_data = '0;
        win_l = 0;
        win_r = 639;
        win_b = 0;
        win_t = 479;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window_directed();
        test_window_extremes();
        test_random_windows(820);
        test_output_backpressure();
        if (errors == 0 && expected_clips.size() == 0)
            $display("line_clipper_2d_tb passed");
        else
            $display("line_clipper_2d_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lc_pkg.sv
hw/rtl/lc_div.sv
hw/rtl/line_clipper_2d.sv
sim/line_clipper_2d_tb.sv
